@@ src/pixel_color_converter_u8_core_defines.svh @@
// Assertion macros for the pixel color converter.
`ifndef PIXEL_COLOR_CONVERTER_U8_CORE_DEFINES_SVH
`define PIXEL_COLOR_CONVERTER_U8_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define PCC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pcc assertion failed");
`define PCC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pcc assertion failed");
`else
`define PCC_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define PCC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

@@ src/pcc_u8_pkg.sv @@
package pcc_u8_pkg;

   localparam logic [3:0] MODE_BGR_GRAY   = 4'd0;
   localparam logic [3:0] MODE_BGRA_GRAY  = 4'd1;
   localparam logic [3:0] MODE_RGBA_GRAY  = 4'd2;
   localparam logic [3:0] MODE_GRAY_BGR   = 4'd3;
   localparam logic [3:0] MODE_GRAY_4CH   = 4'd4;
   localparam logic [3:0] MODE_SWAP3      = 4'd5;
   localparam logic [3:0] MODE_BGR_YUV    = 4'd6;
   localparam logic [3:0] MODE_RGB_YUV    = 4'd7;
   localparam logic [3:0] MODE_YUV_BGR    = 4'd8;
   localparam logic [3:0] MODE_YUV_RGB    = 4'd9;
   localparam logic [3:0] MODE_ADD_ALPHA  = 4'd10;
   localparam logic [3:0] MODE_ADD_ALPHA_SWAP  = 4'd11;
   localparam logic [3:0] MODE_DROP_ALPHA      = 4'd12;
   localparam logic [3:0] MODE_DROP_ALPHA_SWAP = 4'd13;
   localparam logic [3:0] MODE_SWAP4      = 4'd14;
   localparam logic [3:0] MODE_NONE       = 4'd15;

   localparam logic [2:0] COUNT_ONE   = 3'd1;
   localparam logic [2:0] COUNT_THREE = 3'd3;
   localparam logic [2:0] COUNT_FOUR  = 3'd4;

   localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

   typedef struct packed {
      logic [7:0] chan_a;
      logic [7:0] chan_b;
      logic [7:0] chan_c;
      logic [7:0] chan_d;
      logic       frame_end;
   } req_type;

   typedef struct packed {
      logic [7:0] res_a;
      logic [7:0] res_b;
      logic [7:0] res_c;
      logic [7:0] res_d;
      logic [2:0] res_count;
      logic       frame_end_out;
   } rsp_type;

endpackage

@@ src/pixel_color_converter_u8_core.sv @@
// Pipeline: 5 register stages; rsp_strobe is the stage 5 register of the stage 4 valid.
// Throughput: one item per clock; busy is tied low, five-stage pipeline with no stall path.
// Items issued while the mode is 15 give no result.
// Reset (synchronous, active high) clears the mode register to 0 and all stage valids;
// items in flight are dropped. The receiver cannot stall.
`include "pixel_color_converter_u8_core_defines.svh"

module pixel_color_converter_u8_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  pcc_u8_pkg::req_type req_data,
   input  logic                csr_write_en,
   input  logic [3:0]          csr_write_data,
   output logic                rsp_strobe,
   output pcc_u8_pkg::rsp_type rsp_data
);

   localparam logic [23:0] K_GRAY_B = 24'd7471;
   localparam logic [23:0] K_GRAY_G = 24'd38470;
   localparam logic [23:0] K_GRAY_R = 24'd19595;
   localparam logic [23:0] ROUND_16 = 24'd32768;
   localparam logic signed [26:0] K_BU = 27'sd133169;
   localparam logic signed [26:0] K_GU = 27'sd25887;
   localparam logic signed [26:0] K_GV = 27'sd38076;
   localparam logic signed [26:0] K_RV = 27'sd74711;
   localparam logic signed [27:0] ROUND_16S = 28'sd32768;
   localparam logic signed [41:0] K_U = 42'sd32244;
   localparam logic signed [41:0] K_V = 42'sd57475;
   // chroma offset 128 << 32 plus half of 2^32
   localparam logic signed [41:0] CHROMA_BIAS = 42'sh080_8000_0000;

   function automatic logic [7:0] clamp_q16(input logic signed [27:0] x);
      logic [7:0] r;
      if (x[27])
         r = 8'd0;
      else if (|x[26:24])
         r = 8'd255;
      else
         r = x[23:16];
      return r;
   endfunction

   function automatic logic [7:0] clamp_q32(input logic signed [41:0] x);
      logic [7:0] r;
      if (x[41])
         r = 8'd0;
      else if (x[40])
         r = 8'd255;
      else
         r = x[39:32];
      return r;
   endfunction

   // mode register
   logic [3:0] mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= pcc_u8_pkg::MODE_BGR_GRAY;
      end else if (csr_write_en) begin
         mode_ff <= csr_write_data;
      end
   end

   assign busy = 1'b0;

   // stage 1: capture item and mode
   logic       s1_valid_ff, s1_valid_in;
   logic [3:0] s1_mode_ff;
   logic [7:0] s1_a_ff, s1_b_ff, s1_c_ff, s1_d_ff;
   logic       s1_fe_ff;

   assign s1_valid_in = start && !busy && (mode_ff != pcc_u8_pkg::MODE_NONE);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_mode_ff <= mode_ff;
      s1_a_ff    <= req_data.chan_a;
      s1_b_ff    <= req_data.chan_b;
      s1_c_ff    <= req_data.chan_c;
      s1_d_ff    <= req_data.chan_d;
      s1_fe_ff   <= req_data.frame_end;
   end

   // stage 2: weight products
   logic [7:0] blue_in, red_in;
   logic signed [8:0] u_in, v_in;
   logic       s2_valid_ff;
   logic [3:0] s2_mode_ff;
   logic [7:0] s2_a_ff, s2_b_ff, s2_c_ff, s2_d_ff, s2_blue_ff, s2_red_ff;
   logic       s2_fe_ff;
   logic [23:0] s2_pb_ff, s2_pg_ff, s2_pr_ff;
   logic signed [26:0] s2_pbu_ff, s2_pgu_ff, s2_pgv_ff, s2_prv_ff;

   always_comb begin
      if ((s1_mode_ff == pcc_u8_pkg::MODE_RGBA_GRAY) ||
          (s1_mode_ff == pcc_u8_pkg::MODE_RGB_YUV)) begin
         blue_in = s1_c_ff;
         red_in  = s1_a_ff;
      end else begin
         blue_in = s1_a_ff;
         red_in  = s1_c_ff;
      end
   end

   assign u_in = $signed({1'b0, s1_b_ff}) - 9'sd128;
   assign v_in = $signed({1'b0, s1_c_ff}) - 9'sd128;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_mode_ff <= s1_mode_ff;
      s2_a_ff    <= s1_a_ff;
      s2_b_ff    <= s1_b_ff;
      s2_c_ff    <= s1_c_ff;
      s2_d_ff    <= s1_d_ff;
      s2_fe_ff   <= s1_fe_ff;
      s2_blue_ff <= blue_in;
      s2_red_ff  <= red_in;
      s2_pb_ff   <= 24'(blue_in) * K_GRAY_B;
      s2_pg_ff   <= 24'(s1_b_ff) * K_GRAY_G;
      s2_pr_ff   <= 24'(red_in) * K_GRAY_R;
      s2_pbu_ff  <= 27'(u_in) * K_BU;
      s2_pgu_ff  <= 27'(u_in) * K_GU;
      s2_pgv_ff  <= 27'(v_in) * K_GV;
      s2_prv_ff  <= 27'(v_in) * K_RV;
   end

   // stage 3: sums
   logic [23:0] yq_in, gray_sum_in;
   logic [27:0] yy_in;
   logic       s3_valid_ff;
   logic [3:0] s3_mode_ff;
   logic [7:0] s3_a_ff, s3_b_ff, s3_c_ff, s3_d_ff, s3_gray_ff;
   logic       s3_fe_ff;
   logic signed [25:0] s3_db_ff, s3_dr_ff;
   logic signed [27:0] s3_sb_ff, s3_sg_ff, s3_sr_ff;

   assign yq_in       = s2_pb_ff + s2_pg_ff + s2_pr_ff;
   assign gray_sum_in = yq_in + ROUND_16;
   assign yy_in       = 28'({s2_a_ff, 16'h0000});

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s3_mode_ff <= s2_mode_ff;
      s3_a_ff    <= s2_a_ff;
      s3_b_ff    <= s2_b_ff;
      s3_c_ff    <= s2_c_ff;
      s3_d_ff    <= s2_d_ff;
      s3_fe_ff   <= s2_fe_ff;
      s3_gray_ff <= gray_sum_in[23:16];
      s3_db_ff   <= 26'({s2_blue_ff, 16'h0000}) - 26'(yq_in);
      s3_dr_ff   <= 26'({s2_red_ff, 16'h0000}) - 26'(yq_in);
      s3_sb_ff   <= yy_in + 28'(s2_pbu_ff) + ROUND_16S;
      s3_sg_ff   <= yy_in - 28'(s2_pgu_ff) - 28'(s2_pgv_ff) + ROUND_16S;
      s3_sr_ff   <= yy_in + 28'(s2_prv_ff) + ROUND_16S;
   end

   // stage 4: chroma products, inverse clamp
   logic       s4_valid_ff;
   logic [3:0] s4_mode_ff;
   logic [7:0] s4_a_ff, s4_b_ff, s4_c_ff, s4_d_ff, s4_gray_ff;
   logic [7:0] s4_ob_ff, s4_og_ff, s4_or_ff;
   logic       s4_fe_ff;
   logic signed [41:0] s4_pu_ff, s4_pv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s4_mode_ff <= s3_mode_ff;
      s4_a_ff    <= s3_a_ff;
      s4_b_ff    <= s3_b_ff;
      s4_c_ff    <= s3_c_ff;
      s4_d_ff    <= s3_d_ff;
      s4_fe_ff   <= s3_fe_ff;
      s4_gray_ff <= s3_gray_ff;
      s4_pu_ff   <= 42'(s3_db_ff) * K_U;
      s4_pv_ff   <= 42'(s3_dr_ff) * K_V;
      s4_ob_ff   <= clamp_q16(s3_sb_ff);
      s4_og_ff   <= clamp_q16(s3_sg_ff);
      s4_or_ff   <= clamp_q16(s3_sr_ff);
   end

   // stage 5: chroma clamp, channel assembly, output register
   logic [7:0] u_out, v_out;
   pcc_u8_pkg::rsp_type rsp_in;
   logic       rsp_strobe_ff;
   pcc_u8_pkg::rsp_type rsp_data_ff;

   assign u_out = clamp_q32(s4_pu_ff + CHROMA_BIAS);
   assign v_out = clamp_q32(s4_pv_ff + CHROMA_BIAS);

   always_comb begin
      rsp_in = '0;
      rsp_in.frame_end_out = s4_fe_ff;
      rsp_in.res_count     = pcc_u8_pkg::COUNT_THREE;
      unique case (s4_mode_ff) inside
         pcc_u8_pkg::MODE_BGR_GRAY, pcc_u8_pkg::MODE_BGRA_GRAY,
         pcc_u8_pkg::MODE_RGBA_GRAY: begin
            rsp_in.res_a     = s4_gray_ff;
            rsp_in.res_count = pcc_u8_pkg::COUNT_ONE;
         end
         pcc_u8_pkg::MODE_GRAY_BGR: begin
            rsp_in.res_a = s4_a_ff;
            rsp_in.res_b = s4_a_ff;
            rsp_in.res_c = s4_a_ff;
         end
         pcc_u8_pkg::MODE_GRAY_4CH: begin
            rsp_in.res_a     = s4_a_ff;
            rsp_in.res_b     = s4_a_ff;
            rsp_in.res_c     = s4_a_ff;
            rsp_in.res_d     = pcc_u8_pkg::ALPHA_OPAQUE;
            rsp_in.res_count = pcc_u8_pkg::COUNT_FOUR;
         end
         pcc_u8_pkg::MODE_SWAP3, pcc_u8_pkg::MODE_DROP_ALPHA_SWAP: begin
            rsp_in.res_a = s4_c_ff;
            rsp_in.res_b = s4_b_ff;
            rsp_in.res_c = s4_a_ff;
         end
         pcc_u8_pkg::MODE_BGR_YUV, pcc_u8_pkg::MODE_RGB_YUV: begin
            rsp_in.res_a = s4_gray_ff;
            rsp_in.res_b = u_out;
            rsp_in.res_c = v_out;
         end
         pcc_u8_pkg::MODE_YUV_BGR: begin
            rsp_in.res_a = s4_ob_ff;
            rsp_in.res_b = s4_og_ff;
            rsp_in.res_c = s4_or_ff;
         end
         pcc_u8_pkg::MODE_YUV_RGB: begin
            rsp_in.res_a = s4_or_ff;
            rsp_in.res_b = s4_og_ff;
            rsp_in.res_c = s4_ob_ff;
         end
         pcc_u8_pkg::MODE_ADD_ALPHA: begin
            rsp_in.res_a     = s4_a_ff;
            rsp_in.res_b     = s4_b_ff;
            rsp_in.res_c     = s4_c_ff;
            rsp_in.res_d     = pcc_u8_pkg::ALPHA_OPAQUE;
            rsp_in.res_count = pcc_u8_pkg::COUNT_FOUR;
         end
         pcc_u8_pkg::MODE_ADD_ALPHA_SWAP: begin
            rsp_in.res_a     = s4_c_ff;
            rsp_in.res_b     = s4_b_ff;
            rsp_in.res_c     = s4_a_ff;
            rsp_in.res_d     = pcc_u8_pkg::ALPHA_OPAQUE;
            rsp_in.res_count = pcc_u8_pkg::COUNT_FOUR;
         end
         pcc_u8_pkg::MODE_DROP_ALPHA: begin
            rsp_in.res_a = s4_a_ff;
            rsp_in.res_b = s4_b_ff;
            rsp_in.res_c = s4_c_ff;
         end
         pcc_u8_pkg::MODE_SWAP4: begin
            rsp_in.res_a     = s4_c_ff;
            rsp_in.res_b     = s4_b_ff;
            rsp_in.res_c     = s4_a_ff;
            rsp_in.res_d     = s4_d_ff;
            rsp_in.res_count = pcc_u8_pkg::COUNT_FOUR;
         end
         default: begin
            // mode 15 items never get this far
            rsp_in.res_count = pcc_u8_pkg::COUNT_THREE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   `PCC_ASSERT_NEXT(a_issue_reaches_s1, clock, reset,
      start && (mode_ff != pcc_u8_pkg::MODE_NONE), s1_valid_ff)
   `PCC_ASSERT_IMPLY(a_s1_mode_meaningful, clock, reset,
      s1_valid_ff, s1_mode_ff != pcc_u8_pkg::MODE_NONE)
   `PCC_ASSERT_NEXT(a_no_phantom_result, clock, reset, !s4_valid_ff, !rsp_strobe_ff)
   `PCC_ASSERT_IMPLY(a_count_legal, clock, reset, rsp_strobe_ff,
      (rsp_data_ff.res_count == pcc_u8_pkg::COUNT_ONE) ||
      (rsp_data_ff.res_count == pcc_u8_pkg::COUNT_THREE) ||
      (rsp_data_ff.res_count == pcc_u8_pkg::COUNT_FOUR))
   `PCC_ASSERT_IMPLY(a_unused_zero, clock, reset,
      rsp_strobe_ff && (rsp_data_ff.res_count != pcc_u8_pkg::COUNT_FOUR),
      rsp_data_ff.res_d == 8'd0)

endmodule
